>>> rtl/cct_pkg.sv
// Package for the compaction chunk table: action codes, queue entry and engine states.
// No dependencies.
`timescale 1ns / 1ps
package cct_pkg;
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_NOTE  = 2'd1,
    ACT_PLAN  = 2'd2,
    ACT_MAP   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] offset_value;
    logic [15:0] chunk_size;
    logic [15:0] heap_top;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_INS,
    ST_TAIL_RD,
    ST_TAIL_WAIT,
    ST_PLAN_RD,
    ST_PLAN_CMP,
    ST_MAP_RD,
    ST_MAP_WAIT,
    ST_DONE
  } state_t;
endpackage

>>> rtl/cct_if.sv
// Valid/ready channel interfaces for the compaction chunk table.
// Depends on cct_pkg.
`timescale 1ns / 1ps
interface cct_in_if import cct_pkg::*; ();
  logic        valid;
  logic        ready;
  action_t     action;
  logic [15:0] offset_value;
  logic [15:0] chunk_size;
  logic [15:0] heap_top;
  modport source (output valid, action, offset_value, chunk_size, heap_top, input ready);
  modport sink (input valid, action, offset_value, chunk_size, heap_top, output ready);
endinterface

interface cct_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result_offset;
  logic        any_moved;
  logic        table_full;
  logic        inserted;
  modport source (output valid, result_offset, any_moved, table_full, inserted, input ready);
  modport sink (input valid, result_offset, any_moved, table_full, inserted, output ready);
endinterface

>>> rtl/cct_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module cct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/cct_front.sv
// Front end: accepts transfers and holds them in a two-entry command queue.
// Depends on cct_pkg and cct_if.
`timescale 1ns / 1ps
module cct_front import cct_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  cct_in_if.sink   in_ch,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_pop
);
  cmd_t       q_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{in_ch.action, in_ch.offset_value, in_ch.chunk_size, in_ch.heap_top};
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (cmd_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end
endmodule

>>> rtl/cct_back.sv
// Back end: sequencer over the entry RAMs that carries out start, note, plan and map.
// Depends on cct_pkg, cct_if and cct_ram.
`timescale 1ns / 1ps
module cct_back import cct_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  input  cmd_t     cmd,
  output logic     cmd_pop,
  cct_out_if.source out_ch
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

  state_t      state_r, state_nxt;
  cmd_t        c_r;
  logic [CW-1:0] count_r, count_nxt, first_r, first_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [15:0] wlow_r, wlow_nxt, whigh_r, whigh_nxt, top_r, top_nxt;
  logic [15:0] res_r, res_nxt;
  logic        moved_r, moved_nxt, ins_r, ins_nxt, ovalid_r, ovalid_nxt;
  logic        mov_phase_r, mov_phase_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wold, wsz, rold, rsz;
  logic          wold_en;
  logic [CW-1:0] mid, endc;
  logic          inwin;

  cct_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_old (
    .clk(clk), .we(we && wold_en), .waddr(waddr), .wdata(wold), .raddr(raddr), .rdata(rold));
  cct_ram #(.WIDTH(16), .DEPTH(TABLE_ENTRIES)) u_sz (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wsz), .raddr(raddr), .rdata(rsz));

  assign mid   = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign inwin = (c_r.offset_value >= wlow_r) && (c_r.offset_value < whigh_r);
  assign endc  = (count_r == FULL) ? FULL : count_r + 1'b1;

  assign out_ch.valid         = ovalid_r;
  assign out_ch.result_offset = res_r;
  assign out_ch.any_moved     = moved_r;
  assign out_ch.table_full    = (count_r == FULL);
  assign out_ch.inserted      = ins_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !ovalid_r) begin
          unique case (cmd.action)
            ACT_START: state_nxt = ST_DONE;
            ACT_NOTE, ACT_MAP: state_nxt = ST_SRCH_RD;
            ACT_PLAN: state_nxt = ST_PLAN_RD;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SRCH_RD: begin
        if (!inwin) state_nxt = ST_DONE;
        else if (lo_r >= hi_r) begin
          if (c_r.action == ACT_MAP) state_nxt = (lo_r < count_r) ? ST_MAP_RD : ST_DONE;
          else if (lo_r >= FULL) state_nxt = ST_DONE;
          else if (endc > lo_r + 1'b1) state_nxt = ST_SHIFT_RD;
          else state_nxt = ST_INS;
        end else state_nxt = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: state_nxt = ST_SRCH_RD;
      ST_SHIFT_RD: state_nxt = ST_SHIFT_WR;
      ST_SHIFT_WR: state_nxt = (idx_r - 1'b1 > lo_r + 1'b1) ? ST_SHIFT_RD : ST_INS;
      ST_INS: state_nxt = (count_r == FULL || count_r + 1'b1 == FULL) ? ST_TAIL_RD : ST_DONE;
      ST_TAIL_RD: state_nxt = ST_TAIL_WAIT;
      ST_TAIL_WAIT: state_nxt = ST_DONE;
      ST_PLAN_RD: state_nxt = (idx_r < count_r) ? ST_PLAN_CMP : ST_DONE;
      ST_PLAN_CMP: state_nxt = ST_PLAN_RD;
      ST_MAP_RD: state_nxt = ST_MAP_WAIT;
      ST_MAP_WAIT: state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r; first_nxt = first_r; lo_nxt = lo_r; hi_nxt = hi_r;
    idx_nxt = idx_r; wlow_nxt = wlow_r; whigh_nxt = whigh_r; top_nxt = top_r;
    res_nxt = res_r; moved_nxt = moved_r; ins_nxt = ins_r; ovalid_nxt = ovalid_r;
    mov_phase_nxt = mov_phase_r;
    cmd_pop = 1'b0; we = 1'b0; wold_en = 1'b1; waddr = '0; wold = '0; wsz = '0;
    raddr = AW'(mid);
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !ovalid_r) begin
          cmd_pop = 1'b1;
          res_nxt = '0; moved_nxt = 1'b0; ins_nxt = 1'b0;
          lo_nxt = (first_r > count_r) ? count_r : first_r;
          hi_nxt = count_r;
          idx_nxt = '0; mov_phase_nxt = 1'b0;
          top_nxt = cmd.heap_top;
          if (cmd.action == ACT_START) begin
            wlow_nxt = cmd.offset_value; whigh_nxt = cmd.heap_top;
            count_nxt = '0; first_nxt = '0;
          end
          if (cmd.action == ACT_MAP) res_nxt = cmd.offset_value;
        end
      end
      ST_SRCH_RD: begin
        idx_nxt = endc;
      end
      ST_SRCH_CMP: begin
        if (rold < c_r.offset_value) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
      end
      ST_SHIFT_RD: begin
        raddr = AW'(idx_r - 2'd2);
      end
      ST_SHIFT_WR: begin
        we = 1'b1; waddr = AW'(idx_r - 1'b1); wold = rold; wsz = rsz;
        idx_nxt = idx_r - 1'b1;
      end
      ST_INS: begin
        we = 1'b1; waddr = AW'(lo_r); wold = c_r.offset_value; wsz = c_r.chunk_size;
        ins_nxt = 1'b1;
        if (count_r != FULL) count_nxt = count_r + 1'b1;
      end
      ST_TAIL_RD: raddr = AW'(FULL - 1'b1);
      ST_TAIL_WAIT: whigh_nxt = rold + rsz;
      ST_PLAN_RD: begin
        raddr = AW'(idx_r);
        if (idx_r >= count_r) begin
          res_nxt = top_r; moved_nxt = mov_phase_r;
          if (!mov_phase_r) begin
            first_nxt = idx_r; wlow_nxt = whigh_r;
          end
        end
      end
      ST_PLAN_CMP: begin
        idx_nxt = idx_r + 1'b1;
        if (!mov_phase_r && rold <= top_r) top_nxt = top_r + rsz;
        else begin
          if (!mov_phase_r) begin
            mov_phase_nxt = 1'b1; first_nxt = idx_r; wlow_nxt = rold;
          end
          we = 1'b1; wold_en = 1'b0; waddr = AW'(idx_r); wsz = top_r;
          top_nxt = top_r + rsz;
        end
      end
      ST_MAP_RD: raddr = AW'(lo_r);
      ST_MAP_WAIT: res_nxt = rsz;
      ST_DONE: ovalid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && cmd_valid && !ovalid_r) c_r <= cmd;
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt; top_r <= top_nxt;
    res_r <= res_nxt; moved_r <= moved_nxt; ins_r <= ins_nxt;
    mov_phase_r <= mov_phase_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE; count_r <= '0; first_r <= '0;
      wlow_r <= '0; whigh_r <= '0; ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; first_r <= first_nxt;
      wlow_r <= wlow_nxt; whigh_r <= whigh_nxt; ovalid_r <= ovalid_nxt;
    end
  end
endmodule

>>> rtl/compaction_chunk_table.sv
// Top level of the compaction chunk table: command queue front end and table engine.
// Depends on cct_pkg, cct_if, cct_front and cct_back.
//   channel | dir | fields
//   in      | in  | action, offset_value, chunk_size, heap_top
//   out     | out | result_offset, any_moved, table_full, inserted
// Start resets the window and the table count; note and map run a binary search, and note then shifts
// later entries up and reads the tail when it fills the table; plan walks every entry.
// The entry RAM port serializes the work, one item at a time.
// Reset is synchronous and active low; the entry RAMs are not cleared.
// A two-entry queue accepts up to two transfers while the engine or the output stalls.
`timescale 1ns / 1ps
module compaction_chunk_table import cct_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  cct_in_if.sink     in_ch,
  cct_out_if.source  out_ch
);
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  cct_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

  cct_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (.clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop), .out_ch(out_ch));
endmodule

>>> tb/tb_compaction_chunk_table.sv
// Testbench for the compaction chunk table: directed table plus random sequences,
// each result checked against a behavioral forwarding-table predictor.
// Depends on cct_pkg, cct_if and the compaction_chunk_table RTL.
`timescale 1ns / 1ps
module tb_compaction_chunk_table;
  import cct_pkg::*;

  localparam int ENTRIES = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] result_offset;
    logic        any_moved;
    logic        table_full;
    logic        inserted;
  } answer_t;

  typedef struct {
    action_t     action;
    logic [15:0] offset_value;
    logic [15:0] chunk_size;
    logic [15:0] heap_top;
    logic        has_fixed;
    answer_t     fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cct_in_if in_ch();
  cct_out_if out_ch();

  compaction_chunk_table #(.TABLE_ENTRIES(ENTRIES)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [15:0] old_offs[ENTRIES];
  logic [15:0] size_or_new[ENTRIES];
  int unsigned count_q;
  int unsigned first_mov_q;
  logic [15:0] win_low_q;
  logic [15:0] win_high_q;

  answer_t pending_answers[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit sending_done = 1'b0;

  function automatic int unsigned find_slot(logic [15:0] key);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = first_mov_q;
    hi = count_q;
    if (lo > hi) lo = hi;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (old_offs[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic answer_t forward_table_step(action_t act, logic [15:0] off,
                                                 logic [15:0] sz, logic [15:0] top);
    answer_t a;
    int unsigned slot;
    int unsigned last;
    int unsigned i;
    logic [15:0] t;
    a = '0;
    case (act)
      ACT_START: begin
        win_low_q = off;
        win_high_q = top;
        count_q = 0;
        first_mov_q = 0;
      end
      ACT_NOTE: begin
        if (off >= win_low_q && off < win_high_q) begin
          slot = find_slot(off);
          if (slot < ENTRIES) begin
            last = (count_q + 1 > ENTRIES) ? ENTRIES : count_q + 1;
            for (i = last - 1; i > slot; i--) begin
              old_offs[i] = old_offs[i - 1];
              size_or_new[i] = size_or_new[i - 1];
            end
            old_offs[slot] = off;
            size_or_new[slot] = sz;
            if (count_q < ENTRIES) count_q++;
            if (count_q == ENTRIES)
              win_high_q = old_offs[ENTRIES - 1] + size_or_new[ENTRIES - 1];
            a.inserted = 1'b1;
          end
        end
      end
      ACT_PLAN: begin
        t = top;
        i = 0;
        while (i < count_q && old_offs[i] <= t) begin
          t = t + size_or_new[i];
          i++;
        end
        first_mov_q = i;
        if (i < count_q) begin
          win_low_q = old_offs[i];
          a.any_moved = 1'b1;
          for (; i < count_q; i++) begin
            sz = size_or_new[i];
            size_or_new[i] = t;
            t = t + sz;
          end
        end else begin
          win_low_q = win_high_q;
        end
        a.result_offset = t;
      end
      default: begin
        a.result_offset = off;
        if (off >= win_low_q && off < win_high_q) begin
          slot = find_slot(off);
          if (slot < count_q) a.result_offset = size_or_new[slot];
        end
      end
    endcase
    a.table_full = (count_q == ENTRIES);
    return a;
  endfunction

  task automatic send_item(action_t act, logic [15:0] off, logic [15:0] sz,
                           logic [15:0] top, bit has_fixed, answer_t fixed);
    answer_t a;
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.offset_value <= off;
    in_ch.chunk_size <= sz;
    in_ch.heap_top <= top;
    do @(posedge clk); while (!in_ch.ready);
    a = forward_table_step(act, off, sz, top);
    if (has_fixed && a != fixed) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("Directed row disagrees: table %h, predicted %h", fixed, a);
    end
    pending_answers.push_back(a);
  endtask

  // Offsets in a region, mostly well-formed runs of objects inside the window.
  task automatic random_phase(int n_notes);
    logic [15:0] lo;
    logic [15:0] span;
    logic [15:0] off;
    int k;
    lo = $urandom_range(0, 1) ? 16'($urandom_range(0, 40000)) : 16'($urandom);
    span = 16'($urandom_range(16, 8000));
    send_item(ACT_START, lo, 16'($urandom), lo + span, 1'b0, '0);
    for (k = 0; k < n_notes; k++) begin
      off = ($urandom_range(0, 9) == 0) ? 16'($urandom) : lo + 16'($urandom_range(0, span));
      send_item(ACT_NOTE, off,
                $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 128)),
                16'($urandom), 1'b0, '0);
      if ($urandom_range(0, 7) == 0)
        send_item(ACT_MAP, lo + 16'($urandom_range(0, span)), 16'($urandom),
                  16'($urandom), 1'b0, '0);
    end
    send_item(ACT_PLAN, 16'($urandom), 16'($urandom),
              $urandom_range(0, 1) ? lo - 16'($urandom_range(0, 64)) : 16'($urandom),
              1'b0, '0);
    for (k = 0; k < 6; k++) begin
      off = (k < 4 && count_q > 0) ? old_offs[$urandom_range(0, count_q - 1)] : 16'($urandom);
      send_item(ACT_MAP, off, 16'($urandom), 16'($urandom), 1'b0, '0);
    end
    if ($urandom_range(0, 4) == 0)
      send_item(ACT_PLAN, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  row_t rows[$];
  int sent;

  function automatic row_t mk(action_t act, logic [15:0] off, logic [15:0] sz,
                              logic [15:0] top, bit has_fixed, answer_t fixed);
    row_t r;
    r.action = act;
    r.offset_value = off;
    r.chunk_size = sz;
    r.heap_top = top;
    r.has_fixed = has_fixed;
    r.fixed = fixed;
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.offset_value = '0;
    in_ch.chunk_size = '0;
    in_ch.heap_top = '0;
    out_ch.ready = 1'b0;
    count_q = 0;
    first_mov_q = 0;
    win_low_q = '0;
    win_high_q = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    rows.push_back(mk(ACT_MAP, 16'hFFFF, 16'h0000, 16'h0000, 1'b1,
                      '{16'hFFFF, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_NOTE, 16'h0000, 16'h0010, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_PLAN, 16'h0000, 16'h0000, 16'hFFFF, 1'b1,
                      '{16'hFFFF, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_START, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_NOTE, 16'hFFFF, 16'h0001, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_NOTE, 16'h0100, 16'hFFFF, 16'hFFFF, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b1}));
    rows.push_back(mk(ACT_NOTE, 16'h0040, 16'h0020, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b1}));
    rows.push_back(mk(ACT_NOTE, 16'h0000, 16'h0040, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b1}));
    rows.push_back(mk(ACT_NOTE, 16'h0200, 16'h0010, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_MAP, 16'h0040, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_PLAN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_MAP, 16'h0100, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_MAP, 16'h0150, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_PLAN, 16'h0000, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_PLAN, 16'h0000, 16'h0000, 16'hFFF0, 1'b0, '0));
    rows.push_back(mk(ACT_MAP, 16'h0200, 16'h0000, 16'h0000, 1'b0, '0));
    rows.push_back(mk(ACT_START, 16'hFFFF, 16'h0000, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b0}));
    rows.push_back(mk(ACT_NOTE, 16'hFFFF, 16'h0000, 16'h0000, 1'b1,
                      '{16'h0000, 1'b0, 1'b0, 1'b0}));
    foreach (rows[i])
      send_item(rows[i].action, rows[i].offset_value, rows[i].chunk_size,
                rows[i].heap_top, rows[i].has_fixed, rows[i].fixed);

    // Fill to capacity so the tail drops and the window top is set from the last entry.
    send_item(ACT_START, 16'h1000, 16'h0000, 16'h9000, 1'b0, '0);
    for (int k = 0; k < ENTRIES + 12; k++)
      send_item(ACT_NOTE, 16'h1000 + 16'($urandom_range(0, 32767)), 16'($urandom),
                16'h0000, 1'b0, '0);
    send_item(ACT_PLAN, 16'h0000, 16'h0000, 16'h1000, 1'b0, '0);

    sent = rows.size() + ENTRIES + 14;
    while (sent < 1850) begin
      int n;
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 20);
      random_phase(n);
      sent += n + 8;
    end
    in_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      answer_t got;
      answer_t want;
      got = '{out_ch.result_offset, out_ch.any_moved, out_ch.table_full, out_ch.inserted};
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transfer: %h", got);
      end else begin
        want = pending_answers.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch: expected off=%h moved=%b full=%b ins=%b, ",
                      "got off=%h moved=%b full=%b ins=%b"},
                     want.result_offset, want.any_moved, want.table_full, want.inserted,
                     got.result_offset, got.any_moved, got.table_full, got.inserted);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (sending_done && pending_answers.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end
endmodule
